@@ rtl/core/ipd_pkg.sv @@
`timescale 1ns / 1ps

package ipd_pkg;

    localparam int unsigned ID_W       = 4;
    localparam int unsigned LEN_W      = 10;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned MARKER_LEN = 5;

    // Hard ceiling on a declared payload length
    localparam logic [LEN_W-1:0] MAX_FRAME_LEN = LEN_W'(512);

    localparam logic [ID_W-1:0]  ID_SAT  = '1;
    localparam logic [LEN_W-1:0] LEN_SAT = '1;

    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    // Result codes
    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_MALFORMED = 1'b1;
    localparam logic CAUSE_ID       = 1'b0;
    localparam logic CAUSE_LEN      = 1'b1;

    // Configuration register indexes
    localparam logic REG_MAX_CONN_ID     = 1'b0;
    localparam logic REG_MAX_PAYLOAD_LEN = 1'b1;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_ID   = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_DATA = 4'b1000
    } phase_t;

    typedef struct packed {
        logic              out_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [ID_W-1:0]   frame_conn_id;
        logic              frame_end;
        logic              error_cause;
    } result_t;

    // "+IPD," one character per position
    function automatic logic [BYTE_W-1:0] marker_char(input logic [2:0] pos);
        logic [BYTE_W-1:0] c;
        unique case (pos)
            3'd0:    c = 8'h2B;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h44;
            3'd4:    c = 8'h2C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/ipd_byte_if.sv @@
`timescale 1ns / 1ps

interface ipd_byte_if
    import ipd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/core/ipd_result_if.sv @@
`timescale 1ns / 1ps

interface ipd_result_if
    import ipd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              out_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [ID_W-1:0]   frame_conn_id;
    logic              frame_end;
    logic              error_cause;

    modport source (
        output valid, output out_kind, output payload_byte, output frame_conn_id,
        output frame_end, output error_cause, input ready
    );
    modport sink (
        input valid, input out_kind, input payload_byte, input frame_conn_id,
        input frame_end, input error_cause, output ready
    );
endinterface

@@ rtl/core/ipd_parser.sv @@
`timescale 1ns / 1ps

module ipd_parser
    import ipd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    ipd_byte_if.sink         in_ch,
    input  logic [ID_W-1:0]  max_conn_id,
    input  logic [LEN_W-1:0] max_payload_len,
    input  logic             q_full,
    output logic             q_push,
    output result_t          q_data
);

    phase_t           phase_reg, phase_next;
    logic [2:0]       pos_reg, pos_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic             seen_reg, seen_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] left_reg, left_next;

    logic             accept;
    logic [BYTE_W-1:0] b;
    logic             is_digit;
    logic [3:0]       digit;
    logic [7:0]       id_prod;
    logic [13:0]      len_prod;
    logic             marker_hit;
    logic             last_byte;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign b           = in_ch.rx_byte;

    assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    assign digit    = is_digit ? b[3:0] : 4'd0;

    // x*10 + d as shift-and-add
    assign id_prod  = {1'b0, id_reg, 3'b000} + {3'b000, id_reg, 1'b0} + {4'b0000, digit};
    assign len_prod = {1'b0, len_reg, 3'b000} + {3'b000, len_reg, 1'b0}
                    + {10'd0, digit};

    assign marker_hit = (b == marker_char(pos_reg));
    assign last_byte  = (left_reg <= LEN_W'(1));

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        id_next    = id_reg;
        seen_next  = seen_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        q_push     = 1'b0;
        q_data     = '0;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (marker_hit)
                begin
                    pos_next = pos_reg + 3'd1;
                end
                else
                begin
                    pos_next = (b == CHAR_PLUS) ? 3'd1 : 3'd0;
                end
                if (marker_hit && (pos_reg == 3'(MARKER_LEN - 1)))
                begin
                    pos_next   = 3'd0;
                    phase_next = PH_ID;
                    id_next    = '0;
                    seen_next  = 1'b0;
                end
            end

            PH_ID:
            begin
                if (is_digit)
                begin
                    id_next   = (id_prod > 8'(ID_SAT)) ? ID_SAT : id_prod[ID_W-1:0];
                    seen_next = 1'b1;
                end
                else if ((b == CHAR_COMMA) && seen_reg && (id_reg <= max_conn_id))
                begin
                    phase_next = PH_LEN;
                    len_next   = '0;
                    seen_next  = 1'b0;
                end
                else
                begin
                    q_push            = 1'b1;
                    q_data.out_kind   = KIND_MALFORMED;
                    q_data.error_cause = CAUSE_ID;
                end
            end

            PH_LEN:
            begin
                if (is_digit)
                begin
                    len_next  = (len_prod > 14'(LEN_SAT)) ? LEN_SAT : len_prod[LEN_W-1:0];
                    seen_next = 1'b1;
                end
                else if ((b == CHAR_COLON) && seen_reg && (len_reg != '0)
                         && (len_reg <= max_payload_len) && (len_reg <= MAX_FRAME_LEN))
                begin
                    phase_next = PH_DATA;
                    left_next  = len_reg;
                    seen_next  = 1'b0;
                end
                else
                begin
                    q_push             = 1'b1;
                    q_data.out_kind    = KIND_MALFORMED;
                    q_data.error_cause = CAUSE_LEN;
                end
            end

            PH_DATA:
            begin
                q_push               = 1'b1;
                q_data.out_kind      = KIND_PAYLOAD;
                q_data.payload_byte  = b;
                q_data.frame_conn_id = id_reg;
                q_data.frame_end     = last_byte;
                q_data.error_cause   = CAUSE_ID;
                if (!last_byte)
                begin
                    left_next = left_reg - LEN_W'(1);
                end
            end

            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase

        // malformed header or finished frame: back to hunting
        if (q_push && (q_data.out_kind == KIND_MALFORMED || q_data.frame_end))
        begin
            phase_next = PH_HUNT;
            pos_next   = 3'd0;
            id_next    = '0;
            seen_next  = 1'b0;
            len_next   = '0;
            left_next  = '0;
        end

        if (!accept)
        begin
            q_push = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pos_reg   <= '0;
            id_reg    <= '0;
            seen_reg  <= 1'b0;
            len_reg   <= '0;
            left_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            id_reg    <= id_next;
            seen_reg  <= seen_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
        end
    end

endmodule

@@ rtl/core/ipd_out_queue.sv @@
`timescale 1ns / 1ps

module ipd_out_queue
    import ipd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  result_t     push_data,
    output logic        full,
    ipd_result_if.source out_ch
);

    localparam int unsigned DEPTH = 2;

    result_t    mem_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;
    result_t    head;

    assign full = (count_reg == 2'(DEPTH));
    assign pop  = out_ch.valid && out_ch.ready;
    assign head = mem_reg[rd_ptr_reg];

    assign out_ch.valid         = (count_reg != 2'd0);
    assign out_ch.out_kind      = head.out_kind;
    assign out_ch.payload_byte  = head.payload_byte;
    assign out_ch.frame_conn_id = head.frame_conn_id;
    assign out_ch.frame_end     = head.frame_end;
    assign out_ch.error_cause   = head.error_cause;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/ipd_frame_deframer.sv @@
`timescale 1ns / 1ps

// Streaming "+IPD,<id>,<len>:<data>" deframer. One received byte per
// transfer on in_ch; a new byte can be accepted every cycle while the
// result queue is not full. Payload bytes leave on out_ch tagged with the
// connection id, the last one flagged by frame_end; a bad header yields
// one malformed transfer (error_cause 0 for the id field, 1 for the
// length field) and the parser resumes hunting for the marker. Each
// result is registered in the queue before it shows on out_ch. The
// front-end parser and the output side are split by a two-entry queue:
// in_ch.ready drops only while that queue is full, so input is
// throttled only by downstream backpressure. Sustained rate is one byte
// per cycle while out_ch is not stalled. Registers (APB, word aligned):
//   0x0 max_conn_id     [3:0]  reset 4
//   0x4 max_payload_len [9:0]  reset 512 (lengths above 512 always fail)

module ipd_frame_deframer
    import ipd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ipd_byte_if.sink     in_ch,
    ipd_result_if.source out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [ID_W-1:0]  max_conn_id_reg, max_conn_id_next;
    logic [LEN_W-1:0] max_len_reg, max_len_next;
    logic             cfg_wr;
    logic             reg_sel;

    logic             q_push;
    logic             q_full;
    result_t          q_data;

    // ---------------------------------------------------------------
    // Config registers; paddr[1:0] ignored (word access)
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        max_conn_id_next = max_conn_id_reg;
        max_len_next     = max_len_reg;
        if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_MAX_CONN_ID:     max_conn_id_next = pwdata[ID_W-1:0];
                REG_MAX_PAYLOAD_LEN: max_len_next     = pwdata[LEN_W-1:0];
                default:             max_len_next     = max_len_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_MAX_CONN_ID:     prdata = 32'(max_conn_id_reg);
            REG_MAX_PAYLOAD_LEN: prdata = 32'(max_len_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_conn_id_reg <= ID_W'(4);
            max_len_reg     <= LEN_W'(512);
        end
        else
        begin
            max_conn_id_reg <= max_conn_id_next;
            max_len_reg     <= max_len_next;
        end
    end

    // ---------------------------------------------------------------
    // Front end: marker hunt, header parse, payload tagging
    // ---------------------------------------------------------------
    ipd_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .max_conn_id     (max_conn_id_reg),
        .max_payload_len (max_len_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_data          (q_data)
    );

    // ---------------------------------------------------------------
    // Back end: result queue driving out_ch
    // ---------------------------------------------------------------
    ipd_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .out_ch    (out_ch)
    );

endmodule

@@ tb/ipd_deframer_checker.sv @@
`timescale 1ns / 1ps

module ipd_deframer_checker
    import ipd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ipd_byte_if         in_ch,
    ipd_result_if       out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int unsigned fail_count,
    output int unsigned due_count
);

    localparam logic [ID_W-1:0]  MAX_ID_RESET  = 4'd4;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 10'd512;
    // "+IPD," with position 0 in the low byte
    localparam logic [MARKER_LEN-1:0][BYTE_W-1:0] IPD_MARK =
        {8'h2C, 8'h44, 8'h50, 8'h49, 8'h2B};

    // parser mirror
    logic [2:0]       match_pos;
    phase_t           phase;
    logic [ID_W-1:0]  id_acc;
    logic             seen_digit;
    logic [LEN_W-1:0] len_acc;
    logic [LEN_W-1:0] left_n;
    logic [ID_W-1:0]  max_id;
    logic [LEN_W-1:0] max_len;

    result_t     frame_results_due[$];
    result_t     want;
    result_t     got;
    result_t     step_res;
    int unsigned fails = 0;
    int unsigned due_n = 0;

    assign fail_count = fails;
    assign due_count  = due_n;

    function automatic void restart_hunt();
        phase      = PH_HUNT;
        match_pos  = '0;
        id_acc     = '0;
        seen_digit = 1'b0;
        len_acc    = '0;
        left_n     = '0;
    endfunction

    // one received byte; returns 1 when it yields a result
    function automatic bit deframe_step(input logic [BYTE_W-1:0] b, output result_t r);
        bit is_dig;
        int v;
        r      = '0;
        is_dig = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        case (phase)
            PH_HUNT:
            begin
                if (b == IPD_MARK[match_pos])
                    match_pos = match_pos + 3'd1;
                else
                    match_pos = (b == CHAR_PLUS) ? 3'd1 : 3'd0;
                if (match_pos == 3'(MARKER_LEN))
                begin
                    match_pos  = '0;
                    phase      = PH_ID;
                    id_acc     = '0;
                    seen_digit = 1'b0;
                end
                return 1'b0;
            end
            PH_ID:
            begin
                if (is_dig)
                begin
                    v          = int'(id_acc) * 10 + int'(b - CHAR_ZERO);
                    id_acc     = (v > 15) ? ID_SAT : ID_W'(v);
                    seen_digit = 1'b1;
                    return 1'b0;
                end
                if (b == CHAR_COMMA && seen_digit && id_acc <= max_id)
                begin
                    phase      = PH_LEN;
                    len_acc    = '0;
                    seen_digit = 1'b0;
                    return 1'b0;
                end
                r.out_kind    = KIND_MALFORMED;
                r.error_cause = CAUSE_ID;
                restart_hunt();
                return 1'b1;
            end
            PH_LEN:
            begin
                if (is_dig)
                begin
                    v          = int'(len_acc) * 10 + int'(b - CHAR_ZERO);
                    len_acc    = (v > 1023) ? LEN_SAT : LEN_W'(v);
                    seen_digit = 1'b1;
                    return 1'b0;
                end
                if (b == CHAR_COLON && seen_digit && len_acc != '0 &&
                    len_acc <= max_len && len_acc <= MAX_FRAME_LEN)
                begin
                    phase      = PH_DATA;
                    left_n     = len_acc;
                    seen_digit = 1'b0;
                    return 1'b0;
                end
                r.out_kind    = KIND_MALFORMED;
                r.error_cause = CAUSE_LEN;
                restart_hunt();
                return 1'b1;
            end
            default:
            begin
                r.out_kind      = KIND_PAYLOAD;
                r.payload_byte  = b;
                r.frame_conn_id = id_acc;
                r.frame_end     = (left_n <= LEN_W'(1));
                if (left_n <= LEN_W'(1))
                    restart_hunt();
                else
                    left_n = left_n - LEN_W'(1);
                return 1'b1;
            end
        endcase
    endfunction

    task automatic check_field(input string fname, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_hunt();
            max_id  = MAX_ID_RESET;
            max_len = MAX_LEN_RESET;
            frame_results_due.delete();
            due_n <= 0;
        end
        else
        begin
            // results first: anything leaving now belongs to an older byte
            if (out_ch.valid && out_ch.ready)
            begin
                got.out_kind      = out_ch.out_kind;
                got.payload_byte  = out_ch.payload_byte;
                got.frame_conn_id = out_ch.frame_conn_id;
                got.frame_end     = out_ch.frame_end;
                got.error_cause   = out_ch.error_cause;
                if (frame_results_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                    fails++;
                end
                else
                begin
                    want = frame_results_due.pop_front();
                    check_field("out_kind", 8'(want.out_kind), 8'(got.out_kind));
                    check_field("payload_byte", want.payload_byte, got.payload_byte);
                    check_field("frame_conn_id", 8'(want.frame_conn_id),
                                8'(got.frame_conn_id));
                    check_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
                    check_field("error_cause", 8'(want.error_cause), 8'(got.error_cause));
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (deframe_step(in_ch.rx_byte, step_res))
                    frame_results_due.push_back(step_res);
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_MAX_CONN_ID)
                    max_id = pwdata[ID_W-1:0];
                else
                    max_len = pwdata[LEN_W-1:0];
            end
            due_n <= frame_results_due.size();
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the +IPD deframer. The checker beside the DUT
// mirrors the parser and scores every output transfer; this module only
// makes traffic, moves the registers between phases and calls the result.
module tb;
    import ipd_pkg::*;

    localparam int QUIET_LIMIT = 1000;   // cycles with no transfer at all
    localparam int PHASE_BYTES = 130;    // random bytes per register setting
    localparam int SETTLE      = 4;      // parser may still be mid-step

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int unsigned fail_count;
    int unsigned due_count;

    ipd_byte_if   in_ch ();
    ipd_result_if out_ch ();

    ipd_frame_deframer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ipd_deframer_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .due_count  (due_count)
    );

    always #6 clk = ~clk;

    // stimulus-side copy of the limits, only used to shape frames
    int          cfg_id_lim  = 4;
    int          cfg_len_lim = 512;
    bit          tx_calm;
    int unsigned bytes_sent  = 0;
    logic [7:0]  burst_bytes[$];

    // mostly short pauses, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // occasional leading zeros in decimal fields
    function automatic int lead_zeros();
        if ($urandom_range(0, 6) == 0)
            return $urandom_range(1, 2);
        return 0;
    endfunction

    // random byte that is neither a digit nor the expected terminator
    function automatic logic [7:0] junk_byte(input logic [7:0] term);
        logic [7:0] j;
        j = 8'($urandom_range(0, 255));
        while ((j >= CHAR_ZERO && j <= CHAR_NINE) || j == term)
            j = 8'($urandom_range(0, 255));
        return j;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            burst_bytes.push_back(s[i]);
    endtask

    task automatic push_dec(input int v, input int zeros);
        string s;
        s = $sformatf("%0d", v);
        repeat (zeros) burst_bytes.push_back(CHAR_ZERO);
        push_text(s);
    endtask

    task automatic push_payload(input int n);
        repeat (n) burst_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // marker, id and the comma ahead of the length field
    task automatic push_head(input int idv);
        push_text("+IPD,");
        push_dec(idv, lead_zeros());
        burst_bytes.push_back(CHAR_COMMA);
    endtask

    // One byte transfer. valid stays up across back-to-back bytes so it is
    // never lowered and raised in the same step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        bytes_sent++;
        gap = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_queued();
        while (burst_bytes.size() > 0)
            send_byte(burst_bytes.pop_front());
    endtask

    // Drop valid and hold off until every predicted result has drained,
    // plus a settle wait for a byte that gives no result.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // setup cycle, then access cycle; the write lands on the access edge
    task automatic apb_write(input logic regsel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {regsel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_broken(input int idv, input int lim);
        string mark;
        int    k;
        mark = "+IPD,";
        case ($urandom_range(0, 7))
            0: push_text("+IPD,,");
            1:
            begin
                push_text("+IPD,");
                push_dec(idv, 0);
                burst_bytes.push_back(junk_byte(CHAR_COMMA));
            end
            2:
            begin
                push_text("+IPD,");
                if (cfg_id_lim < 15)
                begin
                    push_dec($urandom_range(cfg_id_lim + 1, 15), lead_zeros());
                    burst_bytes.push_back(CHAR_COMMA);
                end
                else
                begin
                    // id saturates to 15 and passes; the empty length fails
                    push_dec($urandom_range(16, 999), 0);
                    push_text(",:");
                end
            end
            3:
            begin
                push_head(idv);
                burst_bytes.push_back(CHAR_COLON);
            end
            4:
            begin
                push_head(idv);
                push_dec(0, lead_zeros());
                burst_bytes.push_back(CHAR_COLON);
            end
            5:
            begin
                push_head(idv);
                if ($urandom_range(0, 4) == 0)
                    push_dec($urandom_range(1024, 99999), 0);
                else
                    push_dec($urandom_range(lim + 1, 1023), 0);
                burst_bytes.push_back(CHAR_COLON);
            end
            6:
            begin
                push_head(idv);
                push_dec($urandom_range(1, 9), 0);
                burst_bytes.push_back(junk_byte(CHAR_COLON));
            end
            default:
            begin
                // marker cut short
                k = $urandom_range(1, 4);
                push_text(mark.substr(0, k - 1));
                burst_bytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Mostly well-formed frames with random content, the rest broken
    // headers and line noise.
    task automatic build_random_item();
        int pick;
        int idv;
        int lenv;
        int lim;
        int cap;
        burst_bytes.delete();
        tx_calm = ($urandom_range(0, 4) == 0);
        lim     = (cfg_len_lim > 512) ? 512 : cfg_len_lim;
        idv     = $urandom_range(0, cfg_id_lim);
        pick    = $urandom_range(0, 99);
        if (pick < 70)
        begin
            if (lim == 0)
                lenv = $urandom_range(1, 8);    // rejected whatever it is
            else
            begin
                cap  = $urandom_range(0, 99);
                cap  = (cap < 88) ? 10 : (cap < 99) ? 60 : lim;
                cap  = (cap > lim) ? lim : cap;
                lenv = $urandom_range(1, cap);
            end
            push_head(idv);
            push_dec(lenv, lead_zeros());
            burst_bytes.push_back(CHAR_COLON);
            push_payload(lenv);
        end
        else if (pick < 85)
            push_broken(idv, lim);
        else
            push_payload($urandom_range(1, 6));
    endtask

    // short hand-picked sequence under the reset limits (id 4, length 512)
    task automatic run_directed();
        burst_bytes.delete();
        tx_calm = 1'b0;
        burst_bytes.push_back(8'h00);           // noise at both byte extremes
        burst_bytes.push_back(8'hFF);
        push_text("+IPD,0,1:");                 // smallest id and length
        burst_bytes.push_back(8'h00);
        push_text("+IPD,4,3:");                 // id at the limit
        burst_bytes.push_back(8'hFF);
        burst_bytes.push_back(8'h55);
        burst_bytes.push_back(8'hAA);
        push_text("+IPD,5,");                   // id above the limit
        push_text("+IPD,,");                    // no id digit
        push_text("+IPD,1x");                   // junk in the id
        push_text("+IPD,999,");                 // id saturates, still too big
        push_text("+IPD,1,:");                  // no length digit
        push_text("+IPD,1,0:");                 // zero length
        push_text("+IPD,1,513:");               // above the ceiling
        push_text("+IPD,1,99999:");             // length saturates
        push_text("+IPD,1,2;");                 // wrong terminator
        push_text("+IPx");                      // marker mismatch
        push_text("+I+IPD,2,2:ab");             // a plus restarts the match
        send_queued();
    endtask

    task automatic run_phase(input int idv, input int lenv, input bit big_frame);
        int unsigned start;
        wait_idle();
        apb_write(REG_MAX_CONN_ID, 32'(idv));
        apb_write(REG_MAX_PAYLOAD_LEN, 32'(lenv));
        cfg_id_lim  = idv;
        cfg_len_lim = lenv;
        if (big_frame)
        begin
            // one frame of the largest length
            burst_bytes.delete();
            tx_calm = 1'b0;
            push_head($urandom_range(0, idv));
            push_dec(512, 0);
            burst_bytes.push_back(CHAR_COLON);
            push_payload(512);
            send_queued();
        end
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES)
        begin
            build_random_item();
            send_queued();
        end
    endtask

    // Receiver: stretches with no stalls, then stretches with random
    // stalls, mostly short and a few long.
    int rx_mode_left = 0;
    int rx_stall     = 0;
    bit rx_calm;

    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_calm      = ($urandom_range(0, 3) == 0);
            rx_mode_left = $urandom_range(50, 300);
        end
        rx_mode_left--;
        if (rx_stall > 0)
        begin
            rx_stall--;
            out_ch.ready <= 1'b0;
        end
        else if (!rx_calm && $urandom_range(0, 99) < 25)
        begin
            rx_stall = idle_len() - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // Watchdog: any transfer or register access resets the count.
    int quiet = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet <= 0;
        else if (quiet + 1 >= QUIET_LIMIT)
        begin
            $display("ipd_frame_deframer test failed");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.rx_byte <= 8'h00;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= 3'd0;
        pwdata        <= 32'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // limit extremes first, zero length limit, then random settings
        run_phase(0, 1, 1'b0);
        run_phase(15, 512, 1'b1);
        run_phase(7, 0, 1'b0);
        run_phase(15, 1023, 1'b0);
        run_phase($urandom_range(0, 15), $urandom_range(1, 512), 1'b0);
        run_phase($urandom_range(0, 15), $urandom_range(1, 512), 1'b0);

        // drain, then give a stray late result time to show up
        wait_idle();
        repeat (12) @(posedge clk);
        if (fail_count == 0 && due_count == 0)
            $display("ipd_frame_deframer test passed");
        else
            $display("ipd_frame_deframer test failed");
        $finish;
    end

endmodule
